// ===== hw/rtl/gradient_stop_table_sampler_macros.svh =====
// ----------------------------------------------------------------------------
// Gradient stop table sampler assertion macros
// Shared property forms for the concurrent checks of the sampler.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_STOP_TABLE_SAMPLER_MACROS_SVH
`define GRADIENT_STOP_TABLE_SAMPLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define GSTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define GSTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/gsts_pkg.sv =====
// ----------------------------------------------------------------------------
// Gradient stop table sampler package
// Widths, Q1.15 constants, status codes and types shared by the sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package gsts_pkg;

	localparam int POS_W         = 16;
	localparam int CH_W          = 16;
	localparam int N_CH          = 4;
	localparam int FRAC_W        = 15;
	localparam int DEF_MAX_STOPS = 8;

	localparam logic [POS_W-1:0] ONE_Q15 = 16'h8000;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_BAD_POS = 2'd1;
	localparam logic [1:0] STAT_BAD_COL = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	// RGBA colour, channel 0 red up to channel 3 alpha
	typedef logic [N_CH-1:0][CH_W-1:0] colour_t;

	// Per-cycle control of the stop cells
	typedef struct packed {
		logic insert;
		logic rotate;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gsts_in_if.sv =====
// ----------------------------------------------------------------------------
// Sampler input channel
// Valid/ready channel carrying one add or sample item.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsts_in_if;
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [15:0]          stop_pos;
	logic [15:0]          red_in;
	logic [15:0]          green_in;
	logic [15:0]          blue_in;
	logic [15:0]          alpha_in;
	logic signed [16:0]   sample_pos;

	modport source (
		output valid, func, stop_pos, red_in, green_in, blue_in, alpha_in, sample_pos,
		input  ready
	);
	modport sink (
		input  valid, func, stop_pos, red_in, green_in, blue_in, alpha_in, sample_pos,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/gsts_out_if.sv =====
// ----------------------------------------------------------------------------
// Sampler result channel
// Valid/ready channel carrying one status and colour item.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsts_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] red_out;
	logic [15:0] green_out;
	logic [15:0] blue_out;
	logic [15:0] alpha_out;

	modport source (
		output valid, status, red_out, green_out, blue_out, alpha_out,
		input  ready
	);
	modport sink (
		input  valid, status, red_out, green_out, blue_out, alpha_out,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/gradient_stop_table_sampler.sv =====
// An add item is checked and its stop inserted in the add state, and its result is then
// registered from the done state. A sample item that falls between two stops first rotates
// the stop ring once past cell zero while the bracketing stops are picked out, then sets up,
// runs the bit-serial fraction divider (15 quotient bits and a done step), takes the four
// channels through the one shared multiplier and adder, and registers the result. A sample
// on an empty table, or at or outside the end stops, skips the divider and the multiplier.
// One item is worked on at a time; the input is ready again in the cycle after the result is
// registered, and a finished result waits in the output register while the next item is
// accepted. A second result stalls in its last cycle until the output register is taken. The
// stop cells have no reset; only the stop count is cleared.
// ----------------------------------------------------------------------------
// Gradient stop table sampler
// Sorted chain of gradient stop cells with a serial divider and a shared
// interpolation multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gradient_stop_table_sampler_macros.svh"

module gradient_stop_table_sampler #(
	parameter int MAX_STOPS = gsts_pkg::DEF_MAX_STOPS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	gsts_in_if.sink    cmd,
	gsts_out_if.source res
);

	localparam int CW = $clog2(MAX_STOPS + 1);
	localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_STOPS);
	localparam logic [CW-1:0] SCAN_LAST = CW'(MAX_STOPS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ADD  = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_EVAL = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_MUL  = 3'd5;
	localparam logic [2:0] ST_SUM  = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	logic [2:0]                     state_q;
	logic [CW-1:0]                  cnt_q;
	logic [CW-1:0]                  scan_q;
	logic [1:0]                     ch_q;
	logic                           out_valid_q;
	logic                           hold_q;
	logic                           found_lo_q;
	logic                           found_hi_q;

	logic                           func_q;
	logic [gsts_pkg::POS_W-1:0]     pos_q;
	gsts_pkg::colour_t              new_col_q;
	logic [gsts_pkg::POS_W-1:0]     t_q;
	logic [gsts_pkg::POS_W-1:0]     lo_pos_q;
	logic [gsts_pkg::POS_W-1:0]     hi_pos_q;
	gsts_pkg::colour_t              lo_col_q;
	gsts_pkg::colour_t              hi_col_q;
	logic [gsts_pkg::FRAC_W-1:0]    frac_q;
	logic signed [32:0]             prod_q;
	logic [1:0]                     stat_q;
	gsts_pkg::colour_t              work_col_q;
	logic [1:0]                     out_stat_q;
	gsts_pkg::colour_t              out_col_q;

	logic                           accept;
	logic [gsts_pkg::POS_W-1:0]     t_clamped;
	logic [1:0]                     add_stat;
	gsts_pkg::cell_ctrl_t           cell_ctrl;
	logic                           div_start;
	logic                           div_done;
	logic [gsts_pkg::FRAC_W-1:0]    div_quo;
	logic signed [16:0]             ch_diff;
	logic signed [15:0]             frac_s;
	logic signed [32:0]             prod_d;
	logic signed [32:0]             prod_adj;
	logic signed [17:0]             ch_sum;
	logic                           out_free;

	logic [gsts_pkg::POS_W-1:0]     cell_pos [MAX_STOPS];
	gsts_pkg::colour_t              cell_col [MAX_STOPS];
	logic                           cell_gt  [MAX_STOPS];

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || res.ready;

	// Clamp the sample point to 0..1.0
	always_comb begin
		if (cmd.sample_pos[16]) begin
			t_clamped = '0;
		end else if (cmd.sample_pos[15:0] > gsts_pkg::ONE_Q15) begin
			t_clamped = gsts_pkg::ONE_Q15;
		end else begin
			t_clamped = cmd.sample_pos[15:0];
		end
	end

	// Check a new stop: position, then colour, then room
	always_comb begin
		logic bad_col;
		bad_col = 1'b0;
		for (int c = 0; c < gsts_pkg::N_CH; c++) begin
			if (new_col_q[c] > gsts_pkg::ONE_Q15) begin
				bad_col = 1'b1;
			end
		end
		priority if (pos_q > gsts_pkg::ONE_Q15) begin
			add_stat = gsts_pkg::STAT_BAD_POS;
		end else if (bad_col) begin
			add_stat = gsts_pkg::STAT_BAD_COL;
		end else if (cnt_q == CNT_MAX) begin
			add_stat = gsts_pkg::STAT_FULL;
		end else begin
			add_stat = gsts_pkg::STAT_OK;
		end
	end

	assign cell_ctrl.insert = (state_q == ST_ADD) && (add_stat == gsts_pkg::STAT_OK);
	assign cell_ctrl.rotate = (state_q == ST_SCAN);

	// Chain of stop cells, cell zero at the low end
	for (genvar i = 0; i < MAX_STOPS; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		localparam int NXT = (i + 1) % MAX_STOPS;
		localparam int PRV = (i == 0) ? 0 : i - 1;

		gsts_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl),
			.occupied (IDX < cnt_q),
			.at_count (IDX == cnt_q),
			.new_pos  (pos_q),
			.new_col  (new_col_q),
			.prev_gt  ((i == 0) ? 1'b0 : cell_gt[PRV]),
			.prev_pos (cell_pos[PRV]),
			.prev_col (cell_col[PRV]),
			.next_pos (cell_pos[NXT]),
			.next_col (cell_col[NXT]),
			.gt       (cell_gt[i]),
			.pos      (cell_pos[i]),
			.col      (cell_col[i])
		);
	end

	// Fraction divider
	assign div_start = (state_q == ST_EVAL) && found_hi_q;

	gsts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (t_q - lo_pos_q),
		.divisor  (hi_pos_q - lo_pos_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Shared channel multiply and truncating rescale
	assign ch_diff  = $signed({1'b0, hi_col_q[ch_q]}) - $signed({1'b0, lo_col_q[ch_q]});
	assign frac_s   = $signed({1'b0, frac_q});
	assign prod_d   = ch_diff * frac_s;
	assign prod_adj = prod_q[32] ? (prod_q + 33'sd32767) : prod_q;
	assign ch_sum   = $signed({2'b00, lo_col_q[ch_q]}) + prod_adj[32:15];

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			scan_q      <= '0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
			hold_q      <= 1'b0;
			found_lo_q  <= 1'b0;
			found_hi_q  <= 1'b0;
		end else begin
			// Load a finished result, or drop the one just taken
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q    <= cmd.func ? ST_SCAN : ST_ADD;
						scan_q     <= '0;
						hold_q     <= 1'b0;
						found_lo_q <= 1'b0;
						found_hi_q <= 1'b0;
					end
				end
				ST_ADD: begin
					if (add_stat == gsts_pkg::STAT_OK) begin
						cnt_q <= cnt_q + CW'(1);
					end
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (scan_q < cnt_q && !hold_q) begin
						if (scan_q == '0 && t_q <= cell_pos[0]) begin
							found_lo_q <= 1'b1;
							hold_q     <= 1'b1;
						end else if (cell_pos[0] <= t_q) begin
							found_lo_q <= 1'b1;
						end else begin
							found_hi_q <= 1'b1;
							hold_q     <= 1'b1;
						end
					end
					scan_q <= scan_q + CW'(1);
					if (scan_q == SCAN_LAST) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= found_hi_q ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					if (div_done) begin
						ch_q    <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					ch_q    <= ch_q + 2'd1;
					state_q <= (ch_q == 2'd3) ? ST_DONE : ST_MUL;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item, bracket and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q       <= cmd.func;
			pos_q        <= cmd.stop_pos;
			new_col_q[0] <= cmd.red_in;
			new_col_q[1] <= cmd.green_in;
			new_col_q[2] <= cmd.blue_in;
			new_col_q[3] <= cmd.alpha_in;
			t_q          <= t_clamped;
		end
		if (state_q == ST_ADD) begin
			stat_q     <= add_stat;
			work_col_q <= '0;
		end
		if (state_q == ST_SCAN && scan_q < cnt_q && !hold_q) begin
			if ((scan_q == '0 && t_q <= cell_pos[0]) || cell_pos[0] <= t_q) begin
				lo_pos_q <= cell_pos[0];
				lo_col_q <= cell_col[0];
			end else begin
				hi_pos_q <= cell_pos[0];
				hi_col_q <= cell_col[0];
			end
		end
		if (state_q == ST_EVAL) begin
			stat_q     <= gsts_pkg::STAT_OK;
			work_col_q <= found_lo_q ? lo_col_q : '0;
		end
		if (state_q == ST_DIV && div_done) begin
			frac_q <= div_quo;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_d;
		end
		if (state_q == ST_SUM) begin
			work_col_q[ch_q] <= ch_sum[15:0];
		end
		if (state_q == ST_DONE && out_free) begin
			out_stat_q <= func_q ? gsts_pkg::STAT_OK : stat_q;
			out_col_q  <= work_col_q;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.status    = out_stat_q;
	assign res.red_out   = out_col_q[0];
	assign res.green_out = out_col_q[1];
	assign res.blue_out  = out_col_q[2];
	assign res.alpha_out = out_col_q[3];

	// Checks
	`GSTS_ASSERT_NEXT(a_cnt_hold, state_q != ST_ADD, $stable(cnt_q), "count changed outside an add")
	`GSTS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_MAX, "stop count above table depth")
	`GSTS_ASSERT_NOW(a_hi_needs_lo, found_hi_q, found_lo_q, "upper stop found without lower stop")
	`GSTS_ASSERT_NOW(a_div_in_div, div_done, state_q == ST_DIV, "divider done outside divide")

endmodule

`default_nettype wire

// ===== hw/rtl/gsts_cell.sv =====
// ----------------------------------------------------------------------------
// Gradient stop cell
// Holds one stop; shifts up on insert, rotates down during a sample scan.
// ----------------------------------------------------------------------------
`default_nettype none

module gsts_cell (
	input  wire logic                         clk,
	input  wire gsts_pkg::cell_ctrl_t         ctrl,
	input  wire logic                         occupied,
	input  wire logic                         at_count,
	input  wire logic [gsts_pkg::POS_W-1:0]   new_pos,
	input  wire gsts_pkg::colour_t            new_col,
	input  wire logic                         prev_gt,
	input  wire logic [gsts_pkg::POS_W-1:0]   prev_pos,
	input  wire gsts_pkg::colour_t            prev_col,
	input  wire logic [gsts_pkg::POS_W-1:0]   next_pos,
	input  wire gsts_pkg::colour_t            next_col,
	output logic                              gt,
	output logic [gsts_pkg::POS_W-1:0]        pos,
	output gsts_pkg::colour_t                 col
);

	logic [gsts_pkg::POS_W-1:0] pos_q;
	gsts_pkg::colour_t          col_q;

	// Flag a held stop that lies strictly above the new one
	assign gt  = occupied && (pos_q > new_pos);
	assign pos = pos_q;
	assign col = col_q;

	// Rotate toward cell zero, or open a slot for the new stop
	always_ff @(posedge clk) begin
		if (ctrl.rotate) begin
			pos_q <= next_pos;
			col_q <= next_col;
		end else if (ctrl.insert) begin
			if (prev_gt) begin
				pos_q <= prev_pos;
				col_q <= prev_col;
			end else if (gt || at_count) begin
				pos_q <= new_pos;
				col_q <= new_col;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/gsts_div.sv =====
// ----------------------------------------------------------------------------
// Local fraction divider
// Restoring divider: (dividend << FRAC_W) / divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gsts_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [gsts_pkg::POS_W-1:0]    dividend,
	input  wire logic [gsts_pkg::POS_W-1:0]    divisor,
	output logic                               done,
	output logic [gsts_pkg::FRAC_W-1:0]        quotient
);

	localparam int STEP_W = $clog2(gsts_pkg::FRAC_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(gsts_pkg::FRAC_W - 1);

	logic                             busy_q;
	logic                             done_q;
	logic [STEP_W-1:0]                step_q;
	logic [gsts_pkg::POS_W:0]         rem_q;
	logic [gsts_pkg::POS_W-1:0]       dvs_q;
	logic [gsts_pkg::FRAC_W-1:0]      quo_q;
	logic [gsts_pkg::POS_W:0]         shifted;
	logic                             fits;

	// Shift in a zero and try the divisor
	assign shifted = {rem_q[gsts_pkg::POS_W-1:0], 1'b0};
	assign fits    = shifted >= {1'b0, dvs_q};

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Develop one quotient bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
			quo_q <= {quo_q[gsts_pkg::FRAC_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== sim/gradient_stop_table_sampler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gradient stop table sampler testbench
// Drives add and sample items through the valid/ready channels. A directed
// table comes first: empty table, rejected stops, end and equal-position
// stops. Random items follow, and the table fills over the run. Every result
// is checked field by field against a set value or a predictor of the sorted
// stop table and its interpolation, under random stalls on both sides.
// ----------------------------------------------------------------------------

module gradient_stop_table_sampler_tb;

	typedef gsts_pkg::colour_t colour_t;

	localparam int               N_CH         = gsts_pkg::N_CH;
	localparam int               FRAC_W       = gsts_pkg::FRAC_W;
	localparam logic [15:0]      ONE_Q15      = gsts_pkg::ONE_Q15;
	localparam logic [1:0]       STAT_OK      = gsts_pkg::STAT_OK;
	localparam logic [1:0]       STAT_BAD_POS = gsts_pkg::STAT_BAD_POS;
	localparam logic [1:0]       STAT_BAD_COL = gsts_pkg::STAT_BAD_COL;
	localparam logic [1:0]       STAT_FULL    = gsts_pkg::STAT_FULL;

	localparam int  STOPS       = gsts_pkg::DEF_MAX_STOPS;
	localparam bit  FUNC_ADD    = 1'b0;
	localparam bit  FUNC_SAMPLE = 1'b1;
	localparam int  N_RANDOM    = 1080;
	localparam int  CALM_TAIL   = 150;
	localparam int  PAUSE_AT    = 600;
	localparam int  HOLD_AT     = 400;
	localparam int  HOLD_LEN    = 400;
	localparam int  QUIET_LIMIT = 2000;
	localparam int  DRAIN_WAIT  = 40;
	localparam int  PRINT_CAP   = 50;

	typedef struct packed {
		logic        func;
		logic [15:0] stop_pos;
		colour_t     tint;
		logic [16:0] sample_pos;
	} ramp_item_t;

	typedef struct packed {
		logic [1:0] status;
		colour_t    tint;
	} ramp_result_t;

	typedef struct {
		ramp_item_t   item;
		bit           typed;
		ramp_result_t want;
	} ramp_row_t;

	logic clk;
	logic arst_n;

	gsts_in_if  cmd();
	gsts_out_if res();

	gradient_stop_table_sampler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	// Predictor copy of the stop table
	logic [15:0] stop_at [STOPS];
	colour_t     tint_at [STOPS];
	int          stops_held;

	ramp_result_t colour_q [$];
	ramp_row_t    plan [$];
	int           mismatches;
	int           rx_count;
	int           quiet;
	logic         steady;

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic colour_t rgba(int r, int g, int b, int a);
		colour_t c;
		c[0] = 16'(r);
		c[1] = 16'(g);
		c[2] = 16'(b);
		c[3] = 16'(a);
		return c;
	endfunction

	// Work out the result of one item and update the stop table
	function automatic ramp_result_t predict_ramp(ramp_item_t it);
		ramp_result_t r;
		int           slot, t, lo, hi;
		longint       span, frac, a, b;
		bit           bad_col;
		r = '0;
		if (it.func == FUNC_ADD) begin
			bad_col = 1'b0;
			for (int c = 0; c < N_CH; c++)
				if (it.tint[c] > ONE_Q15)
					bad_col = 1'b1;
			if (it.stop_pos > ONE_Q15) begin
				r.status = STAT_BAD_POS;
			end else if (bad_col) begin
				r.status = STAT_BAD_COL;
			end else if (stops_held >= STOPS) begin
				r.status = STAT_FULL;
			end else begin
				// Insert after every stop of equal position
				slot = stops_held;
				for (int k = 0; k < stops_held; k++)
					if (stop_at[k] > it.stop_pos && slot == stops_held)
						slot = k;
				for (int k = stops_held; k > slot; k--) begin
					stop_at[k] = stop_at[k-1];
					tint_at[k] = tint_at[k-1];
				end
				stop_at[slot] = it.stop_pos;
				tint_at[slot] = it.tint;
				stops_held++;
				r.status = STAT_OK;
			end
			return r;
		end

		// Clamp t to [0, 1.0]
		t = $signed(it.sample_pos);
		if (t < 0)
			t = 0;
		if (t > int'(ONE_Q15))
			t = int'(ONE_Q15);

		if (stops_held == 0)
			return r;
		if (stops_held == 1 || t <= int'(stop_at[0])) begin
			r.tint = tint_at[0];
			return r;
		end
		if (t >= int'(stop_at[stops_held-1])) begin
			r.tint = tint_at[stops_held-1];
			return r;
		end

		// Bracket t and interpolate each channel, truncating toward zero
		hi = stops_held - 1;
		for (int k = stops_held - 1; k >= 0; k--)
			if (int'(stop_at[k]) > t)
				hi = k;
		lo   = hi - 1;
		span = longint'(stop_at[hi]) - longint'(stop_at[lo]);
		frac = ((longint'(t) - longint'(stop_at[lo])) << FRAC_W) / span;
		for (int c = 0; c < N_CH; c++) begin
			a = longint'(tint_at[lo][c]);
			b = longint'(tint_at[hi][c]);
			r.tint[c] = 16'(a + ((b - a) * frac) / longint'(ONE_Q15));
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Directed rows and random fields
	// ------------------------------------------------------------------
	function automatic ramp_row_t stop_row(int pos, int r, int g, int b, int a,
			bit typed, logic [1:0] st);
		ramp_row_t row;
		row.item            = '0;
		row.item.func       = FUNC_ADD;
		row.item.stop_pos   = 16'(pos);
		row.item.tint       = rgba(r, g, b, a);
		row.item.sample_pos = 17'($urandom);
		row.typed           = typed;
		row.want            = '0;
		row.want.status     = st;
		return row;
	endfunction

	// Stop fields carry noise, which a sample must ignore
	function automatic ramp_row_t sample_row(int t, bit typed, colour_t want_tint);
		ramp_row_t row;
		row.item.func       = FUNC_SAMPLE;
		row.item.stop_pos   = 16'($urandom);
		row.item.tint       = {$urandom, $urandom};
		row.item.sample_pos = 17'(t);
		row.typed           = typed;
		row.want.status     = STAT_OK;
		row.want.tint       = want_tint;
		return row;
	endfunction

	function automatic logic [15:0] q15_value();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? ONE_Q15 : 16'd0;
		return 16'($urandom_range(0, 32768));
	endfunction

	function automatic ramp_item_t random_add();
		ramp_item_t it;
		int         kind, ch;
		it.func       = FUNC_ADD;
		it.stop_pos   = q15_value();
		for (int c = 0; c < N_CH; c++)
			it.tint[c] = q15_value();
		it.sample_pos = 17'($urandom);
		kind          = $urandom_range(0, 9);
		if (kind == 0) begin
			it.stop_pos = 16'($urandom_range(32769, 65535));
			it.tint     = {$urandom, $urandom};
		end else if (kind == 1) begin
			ch          = $urandom_range(0, N_CH - 1);
			it.tint[ch] = 16'($urandom_range(32769, 65535));
		end else if (kind <= 4 && stops_held > 0) begin
			it.stop_pos = stop_at[$urandom_range(0, stops_held - 1)];
		end
		return it;
	endfunction

	function automatic ramp_item_t random_sample();
		ramp_item_t it;
		int         pick;
		it.func     = FUNC_SAMPLE;
		it.stop_pos = 16'($urandom);
		it.tint     = {$urandom, $urandom};
		pick        = $urandom_range(0, 7);
		if (pick == 0)
			it.sample_pos = 17'($urandom);
		else if (pick <= 2 && stops_held > 0)
			it.sample_pos = 17'(int'(stop_at[$urandom_range(0, stops_held - 1)])
				+ $urandom_range(0, 2) - 1);
		else
			it.sample_pos = 17'($urandom_range(0, 32768));
		return it;
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------
	// Hold valid low for a random burst, except in calm stretches
	task automatic idle_gap(int n);
		if (n < N_RANDOM - CALM_TAIL && (n % 160) >= 40 && $urandom_range(0, 3) == 0) begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// Offer one item, wait for acceptance, then queue its expected result
	task automatic send_item(ramp_item_t it, bit typed, ramp_result_t want);
		ramp_result_t predicted;
		cmd.valid      <= 1'b1;
		cmd.func       <= it.func;
		cmd.stop_pos   <= it.stop_pos;
		cmd.red_in     <= it.tint[0];
		cmd.green_in   <= it.tint[1];
		cmd.blue_in    <= it.tint[2];
		cmd.alpha_in   <= it.tint[3];
		cmd.sample_pos <= it.sample_pos;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		predicted = predict_ramp(it);
		colour_q.push_back(typed ? want : predicted);
	endtask

	// ------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------
	task automatic flag_mismatch(string what, int got, int want);
		if (mismatches < PRINT_CAP)
			$display("%0t mismatch on result %0d, %s: got %0d, expected %0d",
				$realtime, rx_count, what, got, want);
		mismatches++;
	endtask

	// Pull ready low in random bursts, and once for a long hold-off
	int  stall_left;
	int  hold_left;
	bit  hold_done;
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res.ready <= 1'b0;
		end else if (!hold_done && rx_count >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN - 1;
			res.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res.ready  <= 1'b0;
		end else if (!steady && (rx_count % 128) >= 32 && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 7);
			res.ready  <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	// Check each result on the falling edge before the edge that takes it
	string chan_name [N_CH] = '{"red", "green", "blue", "alpha"};
	always @(negedge clk) begin : check_results
		ramp_result_t got, want;
		if (arst_n && res.valid && res.ready) begin
			got.status = res.status;
			got.tint   = {res.alpha_out, res.blue_out, res.green_out, res.red_out};
			if (colour_q.size() == 0) begin
				flag_mismatch("unexpected result, status", got.status, -1);
			end else begin
				want = colour_q.pop_front();
				if (got.status !== want.status)
					flag_mismatch("status", got.status, want.status);
				for (int c = 0; c < N_CH; c++)
					if (got.tint[c] !== want.tint[c])
						flag_mismatch(chan_name[c], got.tint[c], want.tint[c]);
			end
			rx_count++;
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		ramp_result_t none;
		colour_t      mid_tint, low_tint, top_tint;
		none           = '0;
		mid_tint       = rgba(32768, 0, 16384, 32768);
		low_tint       = rgba(0, 32768, 0, 32768);
		top_tint       = rgba(32768, 32768, 32768, 0);
		arst_n         = 1'b0;
		steady         = 1'b0;
		mismatches     = 0;
		rx_count       = 0;
		quiet          = 0;
		stall_left     = 0;
		hold_left      = 0;
		hold_done      = 1'b0;
		stops_held     = 0;
		res.ready      = 1'b0;
		cmd.valid      = 1'b0;
		cmd.func       = FUNC_ADD;
		cmd.stop_pos   = '0;
		cmd.red_in     = '0;
		cmd.green_in   = '0;
		cmd.blue_in    = '0;
		cmd.alpha_in   = '0;
		cmd.sample_pos = '0;

		// Empty table, then each rejected stop, position checked first
		plan.push_back(sample_row(0, 1'b1, rgba(0, 0, 0, 0)));
		plan.push_back(sample_row(-65536, 1'b1, rgba(0, 0, 0, 0)));
		plan.push_back(stop_row(32769, 0, 0, 0, 0, 1'b1, STAT_BAD_POS));
		plan.push_back(stop_row(65535, 65535, 65535, 65535, 65535, 1'b1, STAT_BAD_POS));
		plan.push_back(stop_row(100, 32769, 0, 0, 0, 1'b1, STAT_BAD_COL));
		plan.push_back(stop_row(100, 0, 65535, 0, 0, 1'b1, STAT_BAD_COL));
		plan.push_back(stop_row(100, 0, 0, 32769, 0, 1'b1, STAT_BAD_COL));
		plan.push_back(stop_row(100, 0, 0, 0, 40000, 1'b1, STAT_BAD_COL));
		// Single stop: any t gives its colour
		plan.push_back(stop_row(16384, 32768, 0, 16384, 32768, 1'b1, STAT_OK));
		plan.push_back(sample_row(65535, 1'b1, mid_tint));
		plan.push_back(sample_row(-1, 1'b1, mid_tint));
		// End stops at 0 and 1.0, then interior samples
		plan.push_back(stop_row(0, 0, 32768, 0, 32768, 1'b1, STAT_OK));
		plan.push_back(stop_row(32768, 32768, 32768, 32768, 0, 1'b1, STAT_OK));
		plan.push_back(sample_row(8192, 1'b0, none.tint));
		plan.push_back(sample_row(16384, 1'b0, none.tint));
		// Equal position goes after the existing stop
		plan.push_back(stop_row(16384, 0, 0, 0, 0, 1'b1, STAT_OK));
		plan.push_back(sample_row(16384, 1'b0, none.tint));
		plan.push_back(sample_row(24576, 1'b0, none.tint));
		plan.push_back(sample_row(32768, 1'b1, top_tint));
		plan.push_back(sample_row(0, 1'b1, low_tint));
		plan.push_back(sample_row(1, 1'b0, none.tint));
		plan.push_back(sample_row(32767, 1'b0, none.tint));
		plan.push_back(sample_row(12345, 1'b0, none.tint));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			idle_gap(i + 40);
			send_item(plan[i].item, plan[i].typed, plan[i].want);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			bit do_add;
			if (n == N_RANDOM - CALM_TAIL)
				steady <= 1'b1;
			// Pause the input until every result is back
			if (n == PAUSE_AT) begin
				cmd.valid <= 1'b0;
				@(posedge clk);
				while (colour_q.size() != 0)
					@(posedge clk);
			end
			idle_gap(n);
			if (stops_held < STOPS)
				do_add = ($urandom_range(0, 39) == 0);
			else
				do_add = ($urandom_range(0, 14) == 0);
			send_item(do_add ? random_add() : random_sample(), 1'b0, none);
		end
		cmd.valid <= 1'b0;

		// Drain, then watch a little longer for stray results
		while (colour_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
